FILE: hdl/bbr_pkg.sv
// Shared definitions for the 5x5 RGB box blur: sizes, payload structs,
// controller states, register indexes and the reciprocal table for the mean.
// Depends on nothing; every other file imports it.
package bbr_pkg;

    localparam int KERNEL_SIZE  = 5;
    localparam int HALF_K       = KERNEL_SIZE / 2;
    localparam int STORE_ROWS   = KERNEL_SIZE - 1;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;

    localparam int CHAN_W       = 8;
    localparam int COL_SUM_W    = 11;
    localparam int WIN_SUM_W    = 13;
    localparam int ROW_CNT_W    = 3;
    localparam int COUNT_W      = 5;
    localparam int XPOS_W       = 10;
    localparam int YPOS_W       = 12;
    localparam int STREAM_Y_W   = 13;
    localparam int LAG_W        = 12;
    localparam int ROW_CMP_W    = 14;
    localparam int COL_CMP_W    = 12;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam int RECIP_SHIFT  = 18;
    localparam int RECIP_W      = 19;
    localparam int PROD_W       = 32;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef pixel_t [STORE_ROWS-1:0] line_word_t;

    typedef struct packed {
        logic              operation;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_end;
    } out_item_t;

    typedef struct packed {
        logic [COL_SUM_W-1:0] red;
        logic [COL_SUM_W-1:0] green;
        logic [COL_SUM_W-1:0] blue;
        logic [ROW_CNT_W-1:0] rows;
    } col_sum_t;

    typedef struct packed {
        logic [WIN_SUM_W-1:0] red;
        logic [WIN_SUM_W-1:0] green;
        logic [WIN_SUM_W-1:0] blue;
        logic [COUNT_W-1:0]   count;
    } win_sum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COLUMN,
        ST_SUM,
        ST_SCALE,
        ST_OUTPUT
    } bbr_state_t;

    // Rounded-up 2^18 / count; exact floor division for sums up to 25 * 255.
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            5'd1:    r = 19'd262144;
            5'd2:    r = 19'd131072;
            5'd3:    r = 19'd87382;
            5'd4:    r = 19'd65536;
            5'd5:    r = 19'd52429;
            5'd6:    r = 19'd43691;
            5'd7:    r = 19'd37450;
            5'd8:    r = 19'd32768;
            5'd9:    r = 19'd29128;
            5'd10:   r = 19'd26215;
            5'd11:   r = 19'd23832;
            5'd12:   r = 19'd21846;
            5'd13:   r = 19'd20165;
            5'd14:   r = 19'd18725;
            5'd15:   r = 19'd17477;
            5'd16:   r = 19'd16384;
            5'd17:   r = 19'd15421;
            5'd18:   r = 19'd14564;
            5'd19:   r = 19'd13798;
            5'd20:   r = 19'd13108;
            5'd21:   r = 19'd12484;
            5'd22:   r = 19'd11916;
            5'd23:   r = 19'd11398;
            5'd24:   r = 19'd10923;
            5'd25:   r = 19'd10486;
            default: r = 19'd262144;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/bbr_line_store.sv
// Line store of the box blur: one word per column holding the four rows above
// the current one, read, shifted and written back once per stream position.
// Depends on bbr_pkg.
module bbr_line_store (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic [bbr_pkg::XPOS_W-1:0]       rd_addr,
    input  logic                             wr_en,
    input  bbr_pkg::pixel_t                  pixel,
    input  logic [bbr_pkg::STREAM_Y_W-1:0]   row,
    input  logic [bbr_pkg::HEIGHT_REG_W-1:0] height,
    output bbr_pkg::col_sum_t                col_sum
);
    import bbr_pkg::*;

    line_word_t              mem [0:MAX_WIDTH-1];
    line_word_t              rd_word_reg;
    logic [XPOS_W-1:0]       addr_reg;
    line_word_t              wb_word;
    pixel_t                  col_pix [KERNEL_SIZE];
    logic [KERNEL_SIZE-1:0]  row_ok;
    logic [ROW_CMP_W-1:0]    row_ext;
    logic [ROW_CMP_W-1:0]    height_ext;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_reg] <= wb_word;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    assign row_ext    = ROW_CMP_W'(row);
    assign height_ext = ROW_CMP_W'(height);

    always_comb begin
        for (int j = 0; j < STORE_ROWS; j++) begin
            col_pix[j] = rd_word_reg[j];
        end
        col_pix[STORE_ROWS] = pixel;
        for (int j = 0; j < STORE_ROWS - 1; j++) begin
            wb_word[j] = rd_word_reg[j+1];
        end
        wb_word[STORE_ROWS-1] = pixel;
    end

    // Entry j holds row (row - STORE_ROWS + j); it counts only inside the frame.
    always_comb begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            row_ok[j] = (row_ext + ROW_CMP_W'(j) >= ROW_CMP_W'(STORE_ROWS)) &&
                        (row_ext + ROW_CMP_W'(j) < height_ext + ROW_CMP_W'(STORE_ROWS));
        end
    end

    always_comb begin
        col_sum = '0;
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            if (row_ok[j]) begin
                col_sum.red   = col_sum.red   + COL_SUM_W'(col_pix[j].red);
                col_sum.green = col_sum.green + COL_SUM_W'(col_pix[j].green);
                col_sum.blue  = col_sum.blue  + COL_SUM_W'(col_pix[j].blue);
            end
        end
        col_sum.rows = ROW_CNT_W'($countones(row_ok));
    end

endmodule

FILE: hdl/bbr_window.sv
// Window of the box blur: shift register of five column sums and the masked
// sum over the columns that lie inside the frame around the output pixel.
// Depends on bbr_pkg.
module bbr_window (
    input  logic                            aclk,
    input  logic                            push_en,
    input  bbr_pkg::col_sum_t               col_in,
    input  logic                            sum_en,
    input  logic [bbr_pkg::XPOS_W-1:0]      ox,
    input  logic [bbr_pkg::WIDTH_REG_W-1:0] width,
    output bbr_pkg::win_sum_t               win_out
);
    import bbr_pkg::*;

    col_sum_t               slot_reg [KERNEL_SIZE];
    win_sum_t               win_reg;
    win_sum_t               win_next;
    logic [KERNEL_SIZE-1:0] slot_ok;
    logic [COL_CMP_W-1:0]   ox_ext;

    always_ff @(posedge aclk) begin
        if (push_en) begin
            slot_reg[0] <= col_in;
            for (int k = 1; k < KERNEL_SIZE; k++) begin
                slot_reg[k] <= slot_reg[k-1];
            end
        end
        if (sum_en) begin
            win_reg <= win_next;
        end
    end

    // Slot k was pushed k positions ago and holds column ox + HALF_K - k.
    assign ox_ext = COL_CMP_W'(ox) + COL_CMP_W'(HALF_K);

    always_comb begin
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            slot_ok[k] = (ox_ext >= COL_CMP_W'(k)) &&
                         (ox_ext < COL_CMP_W'(width) + COL_CMP_W'(k));
        end
    end

    always_comb begin
        win_next = '0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            if (slot_ok[k]) begin
                win_next.red   = win_next.red   + WIN_SUM_W'(slot_reg[k].red);
                win_next.green = win_next.green + WIN_SUM_W'(slot_reg[k].green);
                win_next.blue  = win_next.blue  + WIN_SUM_W'(slot_reg[k].blue);
                win_next.count = win_next.count + COUNT_W'(slot_reg[k].rows);
            end
        end
    end

    assign win_out = win_reg;

endmodule

FILE: hdl/bbr_divide.sv
// Mean stage of the box blur: multiplies each channel sum by the reciprocal
// of the neighbour count and keeps the integer part of the quotient.
// Depends on bbr_pkg.
module bbr_divide (
    input  logic              aclk,
    input  logic              mul_en,
    input  bbr_pkg::win_sum_t win_in,
    output bbr_pkg::pixel_t   quot
);
    import bbr_pkg::*;

    logic [PROD_W-1:0]  prod_r_reg;
    logic [PROD_W-1:0]  prod_g_reg;
    logic [PROD_W-1:0]  prod_b_reg;
    logic [RECIP_W-1:0] recip;

    assign recip = recip_lookup(win_in.count);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_r_reg <= PROD_W'(win_in.red)   * PROD_W'(recip);
            prod_g_reg <= PROD_W'(win_in.green) * PROD_W'(recip);
            prod_b_reg <= PROD_W'(win_in.blue)  * PROD_W'(recip);
        end
    end

    assign quot.red   = prod_r_reg[RECIP_SHIFT +: CHAN_W];
    assign quot.green = prod_g_reg[RECIP_SHIFT +: CHAN_W];
    assign quot.blue  = prod_b_reg[RECIP_SHIFT +: CHAN_W];

endmodule

FILE: hdl/box_blur_5x5_rgb_core.sv
// 5x5 mean blur of an RGB frame streamed in raster order; each output is the
// truncated per-channel mean of its in-frame neighbors and appears two rows plus two
// pixels after its own input, with drain transfers releasing the rest after
// the last pixel. A pixel that releases an output also waits for the output
// register to be free, and a drain steps through each extra position when the
// frame is smaller than the lag. Each position is a line store read, then a
// shifted write-back of that column.
// Depends on bbr_pkg, bbr_line_store, bbr_window and bbr_divide.
module box_blur_5x5_rgb_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bbr_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bbr_pkg::out_item_t             m_data
);
    import bbr_pkg::*;

    bbr_state_t               state_reg;
    bbr_state_t               state_next;
    logic [WIDTH_REG_W-1:0]   width_reg;
    logic [HEIGHT_REG_W-1:0]  height_reg;
    logic [XPOS_W-1:0]        sx_reg;
    logic [STREAM_Y_W-1:0]    sy_reg;
    logic                     in_done_reg;
    logic [LAG_W-1:0]         pre_cnt_reg;
    logic [XPOS_W-1:0]        ox_reg;
    logic [YPOS_W-1:0]        oy_reg;
    logic                     drain_reg;
    pixel_t                   pixel_reg;
    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic [WIDTH_REG_W-1:0]   eff_w;
    logic [HEIGHT_REG_W-1:0]  eff_h;
    logic [HEIGHT_REG_W-1:0]  h_last;
    logic [XPOS_W-1:0]        w_last;
    logic [LAG_W-1:0]         lag;
    logic                     take_step;
    logic                     emit_now;
    logic                     last_out;
    logic                     out_free;
    logic                     rd_en;
    logic                     col_en;
    logic                     sum_en;
    logic                     mul_en;
    logic                     out_load;
    col_sum_t                 col_sum;
    win_sum_t                 win_sum;
    pixel_t                   quot;

    assign eff_w = (width_reg == '0) ? WIDTH_REG_W'(1) :
                   (width_reg > WIDTH_REG_W'(MAX_WIDTH)) ? WIDTH_REG_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (height_reg == '0) ? HEIGHT_REG_W'(1) :
                   (height_reg > HEIGHT_REG_W'(MAX_HEIGHT)) ? HEIGHT_REG_W'(MAX_HEIGHT) :
                   height_reg;
    assign w_last = XPOS_W'(eff_w - WIDTH_REG_W'(1));
    assign h_last = eff_h - HEIGHT_REG_W'(1);
    assign lag    = LAG_W'(HALF_K) * LAG_W'(eff_w) + LAG_W'(HALF_K);

    assign take_step = (s_data.operation == OP_DRAIN) ? in_done_reg : !in_done_reg;
    assign emit_now  = (pre_cnt_reg == lag);
    assign last_out  = (ox_reg == w_last) && (oy_reg == YPOS_W'(h_last));
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && take_step) begin
                    state_next = ST_COLUMN;
                end
            end
            ST_READ: begin
                state_next = ST_COLUMN;
            end
            ST_COLUMN: begin
                priority if (emit_now) begin
                    state_next = ST_SUM;
                end else if (drain_reg) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        rd_en    = ((state_reg == ST_IDLE) && s_valid && take_step) || (state_reg == ST_READ);
        col_en   = (state_reg == ST_COLUMN);
        sum_en   = (state_reg == ST_SUM);
        mul_en   = (state_reg == ST_SCALE);
        out_load = (state_reg == ST_OUTPUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            sx_reg      <= '0;
            sy_reg      <= '0;
            in_done_reg <= 1'b0;
            pre_cnt_reg <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            drain_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && s_valid) begin
                drain_reg <= (s_data.operation == OP_DRAIN);
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
            end
            if (cfg_we || (out_load && last_out)) begin
                sx_reg      <= '0;
                sy_reg      <= '0;
                in_done_reg <= 1'b0;
                pre_cnt_reg <= '0;
                ox_reg      <= '0;
                oy_reg      <= '0;
            end else begin
                if (col_en) begin
                    if (sx_reg == w_last) begin
                        sx_reg <= '0;
                        sy_reg <= sy_reg + STREAM_Y_W'(1);
                    end else begin
                        sx_reg <= sx_reg + XPOS_W'(1);
                    end
                    if (!drain_reg && (sx_reg == w_last) && (sy_reg == h_last)) begin
                        in_done_reg <= 1'b1;
                    end
                    if (!emit_now) begin
                        pre_cnt_reg <= pre_cnt_reg + LAG_W'(1);
                    end
                end
                if (out_load) begin
                    if (ox_reg == w_last) begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + YPOS_W'(1);
                    end else begin
                        ox_reg <= ox_reg + XPOS_W'(1);
                    end
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            pixel_reg.red   <= s_data.red_in;
            pixel_reg.green <= s_data.green_in;
            pixel_reg.blue  <= s_data.blue_in;
        end
        if (out_load) begin
            m_data_reg.red_out   <= quot.red;
            m_data_reg.green_out <= quot.green;
            m_data_reg.blue_out  <= quot.blue;
            m_data_reg.frame_end <= last_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    bbr_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (sx_reg),
        .wr_en   (col_en),
        .pixel   (pixel_reg),
        .row     (sy_reg),
        .height  (eff_h),
        .col_sum (col_sum)
    );

    bbr_window u_window (
        .aclk    (aclk),
        .push_en (col_en),
        .col_in  (col_sum),
        .sum_en  (sum_en),
        .ox      (ox_reg),
        .width   (eff_w),
        .win_out (win_sum)
    );

    bbr_divide u_divide (
        .aclk   (aclk),
        .mul_en (mul_en),
        .win_in (win_sum),
        .quot   (quot)
    );

endmodule
